/* design/humidity_pressure_temp_compensation_defines.svh */
// Assertion macros for the compensation pipeline.
`ifndef HUMIDITY_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define HUMIDITY_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define HPTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define HPTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HPTC_ASSERT_IMP(lbl, ante, cons, msg)
`define HPTC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* design/hptc_pkg.sv */
// Shared constants and calibration types for the compensation pipeline.
package hptc_pkg;

  // Pipeline shape
  localparam int TEMP_LAT   = 4;
  localparam int DIV_STAGES = 64;
  localparam int PRES_LAT   = 12 + DIV_STAGES;
  localparam int HUM_LAT    = 10;
  localparam int PIPE_DEPTH = TEMP_LAT + PRES_LAT + 1;

  // Register indexes
  localparam logic [2:0] REG_CAL_TEMP  = 3'd0;
  localparam logic [2:0] REG_CAL_PLOW  = 3'd1;
  localparam logic [2:0] REG_CAL_PHIGH = 3'd2;
  localparam logic [2:0] REG_CAL_PNINE = 3'd3;
  localparam logic [2:0] REG_CAL_HA    = 3'd4;
  localparam logic [2:0] REG_CAL_HB    = 3'd5;

  // Formula constants
  localparam logic signed [33:0] FINE_P_OFFSET = 34'sd128000;
  localparam logic signed [63:0] DIV_SCALE     = 64'sd3125;
  localparam logic [20:0]        P_FULL        = 21'd1048576;
  localparam logic signed [63:0] P_BIAS        = 64'sd140737488355328;
  localparam logic signed [31:0] FINE_H_OFFSET = 32'sd76800;
  localparam logic signed [31:0] HUM_MAX       = 32'sd419430400;
  localparam logic [15:0]        HUM_OFF_CODE  = 16'h8000;
  localparam logic signed [31:0] HUM_Y_BIAS    = 32'sd2097152;
  localparam logic signed [31:0] HUM_X_ROUND   = 32'sd16384;
  localparam logic signed [31:0] HUM_Y_ROUND   = 32'sd8192;
  localparam logic signed [31:0] HUM_H3_BIAS   = 32'sd32768;
  localparam logic signed [31:0] CENTI_ROUND   = 32'sd128;

  typedef struct packed {
    logic signed [15:0] t3;
    logic signed [15:0] t2;
    logic [15:0]        t1;
  } temp_cal_t;

  typedef struct packed {
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } pres_cal_t;

  typedef struct packed {
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [15:0] h4;
    logic signed [15:0] h5;
    logic signed [7:0]  h6;
  } hum_cal_t;

endpackage

/* design/hptc_if.sv */
// Channel interfaces: raw measurement in, compensated result out.
interface hptc_meas_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;
  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface hptc_comp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fine_temperature;
  logic signed [31:0] temperature_centi;
  logic [31:0]        pressure_q24_8;
  logic               pressure_valid;
  logic [16:0]        humidity_q22_10;
  logic               humidity_valid;
  modport source (output valid, fine_temperature, temperature_centi, pressure_q24_8,
                  pressure_valid, humidity_q22_10, humidity_valid, input ready);
  modport sink (input valid, fine_temperature, temperature_centi, pressure_q24_8,
                pressure_valid, humidity_q22_10, humidity_valid, output ready);
endinterface

/* design/humidity_pressure_temp_compensation.sv */
// Throughput: one transaction per cycle unless a stall at the output holds the pipeline;
// the 64-stage pressure divider sets the depth.
// A stall at the output freezes every stage together, so nothing is lost or repeated.
// Reset (synchronous) empties the pipeline and clears all calibration registers to zero.
module humidity_pressure_temp_compensation
  import hptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  hptc_meas_if.sink   meas,
  hptc_comp_if.source comp
);

`include "humidity_pressure_temp_compensation_defines.svh"

  logic [47:0] cal_temperature;
  logic [63:0] cal_pressure_low;
  logic [63:0] cal_pressure_high;
  logic [15:0] cal_pressure_ninth;
  logic [39:0] cal_humidity_a;
  logic [31:0] cal_humidity_b;

  logic                   en;
  logic [PIPE_DEPTH-1:0]  vld;
  logic [19:0]            ap_d [TEMP_LAT];
  logic [15:0]            ah_d [TEMP_LAT];
  logic signed [31:0]     fine;
  logic signed [31:0]     fine_d [PRES_LAT];
  logic [31:0]            pres;
  logic                   pvalid;
  logic [16:0]            hum;
  logic                   hvalid;
  logic [17:0]            hum_d [PRES_LAT-HUM_LAT];
  logic signed [31:0]     fine_o;
  temp_cal_t              tcal;
  pres_cal_t              pcal;
  hum_cal_t               hcal;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temperature    <= '0;
      cal_pressure_low   <= '0;
      cal_pressure_high  <= '0;
      cal_pressure_ninth <= '0;
      cal_humidity_a     <= '0;
      cal_humidity_b     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_TEMP:  cal_temperature    <= cfg_data[47:0];
        REG_CAL_PLOW:  cal_pressure_low   <= cfg_data;
        REG_CAL_PHIGH: cal_pressure_high  <= cfg_data;
        REG_CAL_PNINE: cal_pressure_ninth <= cfg_data[15:0];
        REG_CAL_HA:    cal_humidity_a     <= cfg_data[39:0];
        REG_CAL_HB:    cal_humidity_b     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Coefficient unpacking
  assign tcal = '{t3: cal_temperature[47:32], t2: cal_temperature[31:16],
                  t1: cal_temperature[15:0]};
  assign pcal = '{p1: cal_pressure_low[15:0],  p2: cal_pressure_low[31:16],
                  p3: cal_pressure_low[47:32], p4: cal_pressure_low[63:48],
                  p5: cal_pressure_high[15:0], p6: cal_pressure_high[31:16],
                  p7: cal_pressure_high[47:32], p8: cal_pressure_high[63:48],
                  p9: cal_pressure_ninth};
  assign hcal = '{h1: cal_humidity_a[7:0],   h2: cal_humidity_a[23:8],
                  h3: cal_humidity_a[31:24], h4: cal_humidity_b[15:0],
                  h5: cal_humidity_b[31:16], h6: cal_humidity_a[39:32]};

  // Pipeline advance and valid bits
  assign en         = !vld[PIPE_DEPTH-1] || comp.ready;
  assign meas.ready = en;
  assign comp.valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], meas.valid};
    end
  end

  // Raw pressure and humidity wait for the fine temperature
  always_ff @(posedge clk) begin
    if (en) begin
      ap_d[0] <= meas.raw_pressure;
      ah_d[0] <= meas.raw_humidity;
      for (int i = 1; i < TEMP_LAT; i++) begin
        ap_d[i] <= ap_d[i-1];
        ah_d[i] <= ah_d[i-1];
      end
    end
  end

  hptc_temp u_temp (
    .clk   (clk),
    .en    (en),
    .cal   (tcal),
    .raw_t (meas.raw_temperature),
    .fine  (fine)
  );

  hptc_pres u_pres (
    .clk    (clk),
    .en     (en),
    .cal    (pcal),
    .fine   (fine),
    .raw_p  (ap_d[TEMP_LAT-1]),
    .pres   (pres),
    .pvalid (pvalid)
  );

  hptc_hum u_hum (
    .clk    (clk),
    .en     (en),
    .cal    (hcal),
    .fine   (fine),
    .raw_h  (ah_d[TEMP_LAT-1]),
    .hum    (hum),
    .hvalid (hvalid)
  );

  // Align fine temperature and humidity with the pressure result
  always_ff @(posedge clk) begin
    if (en) begin
      fine_d[0] <= fine;
      for (int i = 1; i < PRES_LAT; i++) begin
        fine_d[i] <= fine_d[i-1];
      end
      hum_d[0] <= {hvalid, hum};
      for (int i = 1; i < PRES_LAT - HUM_LAT; i++) begin
        hum_d[i] <= hum_d[i-1];
      end
    end
  end

  assign fine_o = fine_d[PRES_LAT-1];

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      comp.fine_temperature  <= fine_o;
      comp.temperature_centi <= (fine_o * 32'sd5 + CENTI_ROUND) >>> 8;
      comp.pressure_q24_8    <= pres;
      comp.pressure_valid    <= pvalid;
      comp.humidity_q22_10   <= hum_d[PRES_LAT-HUM_LAT-1][16:0];
      comp.humidity_valid    <= hum_d[PRES_LAT-HUM_LAT-1][17];
    end
  end

  `HPTC_ASSERT_NXT(a_accept_enters, meas.valid && meas.ready, vld[0], "accepted transaction not in first stage")
  `HPTC_ASSERT_IMP(a_pres_zero, comp.valid && !comp.pressure_valid, comp.pressure_q24_8 == '0, "invalid pressure not zero")
  `HPTC_ASSERT_IMP(a_hum_zero, comp.valid && !comp.humidity_valid, comp.humidity_q22_10 == '0, "disabled humidity not zero")
  `HPTC_ASSERT_IMP(a_hum_range, comp.valid, comp.humidity_q22_10 <= 17'd102400, "humidity above full scale")

endmodule

/* design/hptc_temp.sv */
// Temperature compensation: four stages from raw temperature to fine temperature.
module hptc_temp
  import hptc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  temp_cal_t          cal,
  input  logic [19:0]        raw_t,
  output logic signed [31:0] fine
);

  logic signed [31:0] da, d, ma, dd, a, b1;

  always_ff @(posedge clk) begin
    if (en) begin
      // offsets from T1
      da   <= $signed({15'b0, raw_t[19:3]} - {15'b0, cal.t1, 1'b0});
      d    <= $signed({16'b0, raw_t[19:4]} - {16'b0, cal.t1});
      // products
      ma   <= da * cal.t2;
      dd   <= d * d;
      // scale
      a    <= ma >>> 11;
      b1   <= (dd >>> 12) * cal.t3;
      // sum
      fine <= a + (b1 >>> 14);
    end
  end

endmodule

/* design/hptc_div.sv */
// Pipelined restoring divider: one quotient bit per stage, unsigned magnitudes.
module hptc_div
  import hptc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] dividend,
  input  logic [30:0] divisor,
  output logic [63:0] quotient
);

  logic [30:0] rem_q [DIV_STAGES];
  logic [63:0] nq_q  [DIV_STAGES];
  logic [30:0] dv_q  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [30:0] rem_in;
    logic [63:0] nq_in;
    logic [30:0] dv_in;
    logic [31:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = dividend;
      assign dv_in  = divisor;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign dv_in  = dv_q[k-1];
    end

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_in, nq_in[63]};
    assign ge    = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? 31'(trial - {1'b0, dv_in}) : trial[30:0];
        nq_q[k]  <= {nq_in[62:0], ge};
        dv_q[k]  <= dv_in;
      end
    end
  end

  assign quotient = nq_q[DIV_STAGES-1];

endmodule

/* design/hptc_pres.sv */
// Pressure compensation: setup stages, divider, then the correction terms.
module hptc_pres
  import hptc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  pres_cal_t          cal,
  input  logic signed [31:0] fine,
  input  logic [19:0]        raw_p,
  output logic [31:0]        pres,
  output logic               pvalid
);

  logic signed [33:0] v1;
  logic [20:0]        pn1, pn2, pn3, pn4;
  logic signed [63:0] sq, v1p5, v1p2, v2a, sqp3, v1p5_3, v1p2_3;
  logic signed [63:0] v2, v1b, m, num0, num;
  logic signed [30:0] dv;
  logic [63:0]        mag_a;
  logic [30:0]        mag_b;
  logic               neg7, ok7;
  logic               neg_d [DIV_STAGES];
  logic               ok_d  [DIV_STAGES];
  logic [63:0]        quo;
  logic signed [63:0] q0, q1, q2, q3, x1, v2c1, v2c2, v2c3, prod, res;
  logic [63:0]        ll;
  logic [31:0]        lh, hl;
  logic               okq0, okq1, okq2, okq3;

  // setup: offsets, squares, coefficient products, dividend and divisor
  always_ff @(posedge clk) begin
    if (en) begin
      v1     <= 34'(fine) - FINE_P_OFFSET;
      pn1    <= P_FULL - {1'b0, raw_p};
      sq     <= v1 * v1;
      v1p5   <= v1 * cal.p5;
      v1p2   <= v1 * cal.p2;
      pn2    <= pn1;
      v2a    <= sq * cal.p6;
      sqp3   <= sq * cal.p3;
      v1p5_3 <= v1p5;
      v1p2_3 <= v1p2;
      pn3    <= pn2;
      v2     <= v2a + (v1p5_3 <<< 17) + (64'(cal.p4) <<< 35);
      v1b    <= (sqp3 >>> 8) + (v1p2_3 <<< 12);
      pn4    <= pn3;
      m      <= (P_BIAS + v1b) * $signed({48'b0, cal.p1});
      num0   <= ($signed({43'b0, pn4}) <<< 31) - v2;
      dv     <= 31'(m >>> 33);
      num    <= num0 * DIV_SCALE;
      // sign and magnitude for the divider
      neg7   <= num[63] ^ dv[30];
      ok7    <= dv != '0;
      mag_a  <= num[63] ? 64'(-num) : 64'(num);
      mag_b  <= dv[30] ? 31'(-dv) : 31'(dv);
    end
  end

  hptc_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend (mag_a),
    .divisor  (mag_b),
    .quotient (quo)
  );

  // sign and valid ride alongside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      neg_d[0] <= neg7;
      ok_d[0]  <= ok7;
      for (int i = 1; i < DIV_STAGES; i++) begin
        neg_d[i] <= neg_d[i-1];
        ok_d[i]  <= ok_d[i-1];
      end
    end
  end

  // correction terms; P9 product split in 32-bit partials
  always_ff @(posedge clk) begin
    if (en) begin
      q0     <= neg_d[DIV_STAGES-1] ? $signed(-quo) : $signed(quo);
      okq0   <= ok_d[DIV_STAGES-1];
      x1     <= cal.p9 * (q0 >>> 13);
      v2c1   <= (64'(cal.p8) * q0) >>> 19;
      q1     <= q0;
      okq1   <= okq0;
      ll     <= x1[31:0] * 64'(q1[44:13]);
      lh     <= x1[31:0] * 32'(q1 >>> 45);
      hl     <= x1[63:32] * q1[44:13];
      q2     <= q1;
      v2c2   <= v2c1;
      okq2   <= okq1;
      prod   <= $signed(ll + {lh + hl, 32'b0});
      q3     <= q2;
      v2c3   <= v2c2;
      okq3   <= okq2;
      pres   <= okq3 ? res[31:0] : '0;
      pvalid <= okq3;
    end
  end

  assign res = ((q3 + (prod >>> 25) + v2c3) >>> 8) + (64'(cal.p7) <<< 4);

endmodule

/* design/hptc_hum.sv */
// Humidity compensation: ten stages from fine temperature and raw humidity.
module hptc_hum
  import hptc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  hum_cal_t           cal,
  input  logic signed [31:0] fine,
  input  logic [15:0]        raw_h,
  output logic [16:0]        hum,
  output logic               hvalid
);

  logic signed [31:0] v, xr, xr2, h5v, a6, a3, x3, x4, x5, x6, ya, yb, y0, yh, y;
  logic signed [31:0] vv, vv8, vv9, sq, t, vr;
  logic               hv_d [HUM_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      v   <= fine - FINE_H_OFFSET;
      xr  <= $signed({2'b0, raw_h, 14'b0} - {cal.h4[11:0], 20'b0});
      h5v <= cal.h5 * v;
      a6  <= v * cal.h6;
      a3  <= v * $signed({24'b0, cal.h3});
      xr2 <= xr;
      x3  <= (xr2 - h5v + HUM_X_ROUND) >>> 15;
      ya  <= a6 >>> 10;
      yb  <= (a3 >>> 11) + HUM_H3_BIAS;
      y0  <= ya * yb;
      x4  <= x3;
      yh  <= ((y0 >>> 10) + HUM_Y_BIAS) * cal.h2;
      x5  <= x4;
      y   <= (yh + HUM_Y_ROUND) >>> 14;
      x6  <= x5;
      vv  <= x6 * y;
      sq  <= (vv >>> 15) * (vv >>> 15);
      vv8 <= vv;
      t   <= (sq >>> 7) * $signed({24'b0, cal.h1});
      vv9 <= vv8;
      // clamp and drop the low 12 bits
      if (!hv_d[HUM_LAT-2] || vr[31]) begin
        hum <= '0;
      end else if (vr > HUM_MAX) begin
        hum <= HUM_MAX[28:12];
      end else begin
        hum <= vr[28:12];
      end
      hvalid <= hv_d[HUM_LAT-2];
    end
  end

  assign vr = vv9 - (t >>> 4);

  // sentinel flag follows the data
  always_ff @(posedge clk) begin
    if (en) begin
      hv_d[0] <= raw_h != HUM_OFF_CODE;
      for (int i = 1; i < HUM_LAT - 1; i++) begin
        hv_d[i] <= hv_d[i-1];
      end
    end
  end

endmodule

/* tb/hptc_checker.sv */
// Result checker: mirrors the calibration, predicts each compensated result and compares.
module hptc_checker
  import hptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  hptc_meas_if        meas,
  hptc_comp_if        comp,
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          pres_invalid_count,
  output int          hum_invalid_count
);

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] centi;
    logic [31:0] pres;
    logic        pres_ok;
    logic [16:0] hum;
    logic        hum_ok;
  } comp_result_t;

  // Mirror of the calibration registers
  logic [47:0] cal_t;
  logic [63:0] cal_plo;
  logic [63:0] cal_phi;
  logic [15:0] cal_p9;
  logic [39:0] cal_ha;
  logic [31:0] cal_hb;

  comp_result_t expected_q[$];

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16_32(logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [63:0] sx32_64(logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  // Signed 64-bit quotient, truncating; most negative / -1 wraps
  function automatic logic [63:0] quot64(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q  = ma / mb;
    return (a[63] ^ b[63]) ? -q : q;
  endfunction

  function automatic comp_result_t compensate(logic [19:0] raw_t, logic [19:0] raw_p,
                                              logic [15:0] raw_h);
    comp_result_t r;
    logic [31:0] at, ah, t1, t2, t3, a, d, b, fine;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y;
    logic [63:0] ap, p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, q, w1, w2;
    at = {12'b0, raw_t};
    ah = {16'b0, raw_h};
    ap = {44'b0, raw_p};
    // temperature
    t1 = {16'b0, cal_t[15:0]};
    t2 = sx16_32(cal_t[31:16]);
    t3 = sx16_32(cal_t[47:32]);
    a = asr32(((at >> 3) - (t1 << 1)) * t2, 11);
    d = (at >> 4) - t1;
    b = asr32(asr32(d * d, 12) * t3, 14);
    fine = a + b;
    r.fine = fine;
    r.centi = asr32(fine * 32'd5 + 32'd128, 8);
    // pressure
    p1 = {48'b0, cal_plo[15:0]};
    p2 = sx32_64(sx16_32(cal_plo[31:16]));
    p3 = sx32_64(sx16_32(cal_plo[47:32]));
    p4 = sx32_64(sx16_32(cal_plo[63:48]));
    p5 = sx32_64(sx16_32(cal_phi[15:0]));
    p6 = sx32_64(sx16_32(cal_phi[31:16]));
    p7 = sx32_64(sx16_32(cal_phi[47:32]));
    p8 = sx32_64(sx16_32(cal_phi[63:48]));
    p9 = sx32_64(sx16_32(cal_p9));
    v1 = sx32_64(fine) - 64'd128000;
    v2 = v1 * v1 * p6 + ((v1 * p5) << 17) + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
    r.pres = '0;
    r.pres_ok = 1'b0;
    if (v1 != 64'd0) begin
      p = 64'd1048576 - ap;
      p = quot64(((p << 31) - v2) * 64'd3125, v1);
      q = asr64(p, 13);
      w1 = asr64(p9 * q * q, 25);
      w2 = asr64(p8 * p, 19);
      p = asr64(p + w1 + w2, 8) + (p7 << 4);
      r.pres = p[31:0];
      r.pres_ok = 1'b1;
    end
    // humidity
    r.hum = '0;
    r.hum_ok = 1'b0;
    if (raw_h != HUM_OFF_CODE) begin
      h1 = {24'b0, cal_ha[7:0]};
      h2 = sx16_32(cal_ha[23:8]);
      h3 = {24'b0, cal_ha[31:24]};
      h6 = {{24{cal_ha[39]}}, cal_ha[39:32]};
      h4 = sx16_32(cal_hb[15:0]);
      h5 = sx16_32(cal_hb[31:16]);
      v = fine - 32'd76800;
      x = asr32((ah << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
      y = asr32(v * h6, 10) * (asr32(v * h3, 11) + 32'd32768);
      y = asr32(y, 10) + 32'd2097152;
      y = asr32(y * h2 + 32'd8192, 14);
      v = x * y;
      v = v - asr32(asr32(asr32(v, 15) * asr32(v, 15), 7) * h1, 4);
      if (v[31]) v = 32'd0;
      else if (v > 32'd419430400) v = 32'd419430400;
      r.hum = v[28:12];
      r.hum_ok = 1'b1;
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  // Calibration mirror, prediction on accepted input, comparison on accepted output
  always @(posedge clk) begin
    comp_result_t e;
    if (rst) begin
      cal_t <= '0;
      cal_plo <= '0;
      cal_phi <= '0;
      cal_p9 <= '0;
      cal_ha <= '0;
      cal_hb <= '0;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
      pres_invalid_count <= 0;
      hum_invalid_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CAL_TEMP:  cal_t <= cfg_data[47:0];
          REG_CAL_PLOW:  cal_plo <= cfg_data;
          REG_CAL_PHIGH: cal_phi <= cfg_data;
          REG_CAL_PNINE: cal_p9 <= cfg_data[15:0];
          REG_CAL_HA:    cal_ha <= cfg_data[39:0];
          REG_CAL_HB:    cal_hb <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (meas.valid && meas.ready)
        expected_q.push_back(compensate(meas.raw_temperature, meas.raw_pressure,
                                        meas.raw_humidity));
      if (comp.valid && comp.ready) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (!e.pres_ok) pres_invalid_count <= pres_invalid_count + 1;
          if (!e.hum_ok) hum_invalid_count <= hum_invalid_count + 1;
          if ({comp.fine_temperature, comp.temperature_centi, comp.pressure_q24_8,
               comp.pressure_valid, comp.humidity_q22_10, comp.humidity_valid} !== e) begin
            fail_count <= fail_count + 1;
            if (comp.fine_temperature !== e.fine)
              $error("fine_temperature: expected %0d, actual %0d",
                     $signed(e.fine), comp.fine_temperature);
            if (comp.temperature_centi !== e.centi)
              $error("temperature_centi: expected %0d, actual %0d",
                     $signed(e.centi), comp.temperature_centi);
            if (comp.pressure_q24_8 !== e.pres)
              $error("pressure_q24_8: expected %0d, actual %0d", e.pres, comp.pressure_q24_8);
            if (comp.pressure_valid !== e.pres_ok)
              $error("pressure_valid: expected %0d, actual %0d", e.pres_ok,
                     comp.pressure_valid);
            if (comp.humidity_q22_10 !== e.hum)
              $error("humidity_q22_10: expected %0d, actual %0d", e.hum,
                     comp.humidity_q22_10);
            if (comp.humidity_valid !== e.hum_ok)
              $error("humidity_valid: expected %0d, actual %0d", e.hum_ok,
                     comp.humidity_valid);
          end
        end
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top: clock, reset, calibration phases, measurement stimulus and verdict.
module tb_top;
  import hptc_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam int LATENCY = 81;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int          fail_count, pending, result_count, pres_invalid_count, hum_invalid_count;
  int          sent;
  bit          quiet;
  int          sink_hold;
  int          src_hold;

  hptc_meas_if meas();
  hptc_comp_if comp();

  humidity_pressure_temp_compensation i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .meas(meas), .comp(comp)
  );

  hptc_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .meas(meas), .comp(comp), .fail_count(fail_count), .pending(pending),
    .result_count(result_count), .pres_invalid_count(pres_invalid_count),
    .hum_invalid_count(hum_invalid_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Output backpressure in random bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      comp.ready <= 1'b1;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      comp.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      comp.ready <= 1'b0;
      sink_hold <= $urandom_range(0, 8);
    end else begin
      comp.ready <= 1'b1;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  // Load a full calibration set; also pokes an unused index that must be ignored
  task automatic load_cal(logic [47:0] t, logic [63:0] plo, logic [63:0] phi,
                          logic [15:0] p9, logic [39:0] ha, logic [31:0] hb);
    cfg_write(REG_CAL_TEMP, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | 64'(t));
    cfg_write(REG_CAL_PLOW, plo);
    cfg_write(REG_CAL_PHIGH, phi);
    cfg_write(REG_CAL_PNINE, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | 64'(p9));
    cfg_write(REG_CAL_HA, {$urandom, $urandom} & 64'hFFFF_FF00_0000_0000 | 64'(ha));
    cfg_write(REG_CAL_HB, {$urandom, 32'b0} | 64'(hb));
    cfg_write(REG_UNUSED, {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_cal();
    load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
             16'($urandom), 40'({$urandom, $urandom}), $urandom);
  endtask

  // Typical factory calibration of a real part
  task automatic load_typical_cal();
    load_cal({16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'd3024, 16'hD643, 16'd36477},
             {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
             16'd6000, {8'd30, 8'd0, 16'd362, 8'd75}, {16'd50, 16'd313});
  endtask

  // One measurement transaction, with an optional idle burst in front
  task automatic send(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      meas.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    meas.valid <= 1'b1;
    meas.raw_temperature <= rt;
    meas.raw_pressure <= rp;
    meas.raw_humidity <= rh;
    do @(posedge clk); while (!meas.ready);
    sent++;
  endtask

  task automatic send_random();
    logic [15:0] rh;
    case ($urandom_range(0, 3))
      0: rh = 16'($urandom);
      1: rh = HUM_OFF_CODE;
      default: rh = 16'($urandom_range(16'h5000, 16'h9000));
    endcase
    if ($urandom_range(0, 1))
      send(20'($urandom), 20'($urandom), rh);
    else
      send(20'($urandom_range(20'h70000, 20'h90000)),
           20'($urandom_range(20'h40000, 20'h70000)), rh);
  endtask

  // Wait until every result is back, then let the pipeline drain
  task automatic drain();
    meas.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic directed_items();
    send(20'h00000, 20'h00000, 16'h0000);
    send(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send(20'h80000, 20'h80000, HUM_OFF_CODE);
    send(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
    send(20'h7E0F0, 20'h65A20, 16'h6E3C);
    send(20'h55555, 20'hAAAAA, 16'h5555);
    send(20'hAAAAA, 20'h55555, 16'hAAAA);
    send(20'h00001, 20'h00001, 16'h8001);
  endtask

  // Main sequence
  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    sent = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    meas.valid = 1'b0;
    meas.raw_temperature = '0;
    meas.raw_pressure = '0;
    meas.raw_humidity = '0;
    comp.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset calibration: zero divisor everywhere
    directed_items();
    drain();
    load_typical_cal();
    directed_items();
    drain();
    load_cal('1, '1, '1, '1, '1, '1);
    directed_items();
    drain();
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}} | 64'hFFFF, {4{16'h7FFF}},
             16'h8000, {8'h80, 8'hFF, 16'h7FFF, 8'hFF}, {16'h8000, 16'h7FFF});
    directed_items();
    drain();

    // Random part: typical calibration in every third phase, random calibration for the rest
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0) load_typical_cal();
      else load_random_cal();
      if (ph == 9) quiet = 1'b1;
      repeat (130) send_random();
      drain();
    end

    $display("Sent %0d measurements over 14 calibration sets, %0d results checked", sent,
             result_count);
    $display("%0d with pressure invalid, %0d with humidity disabled", pres_invalid_count,
             hum_invalid_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
